FILE: rtl/twsch_pkg.sv
// Shared types, constants and helper functions of the timer wheel scheduler.
package twsch_pkg;

  // Wheel geometry and table size.
  localparam int unsigned SlotsPerLevel = 64;
  localparam int unsigned Levels        = 3;
  localparam int unsigned MaxTimers     = 64;

  // Fixed field widths.
  localparam int unsigned TimeW = 18;
  localparam int unsigned IdW   = 16;

  // Table index and scan counter widths.
  localparam int unsigned IdxW = (MaxTimers > 1) ? $clog2(MaxTimers) : 1;
  localparam int unsigned CntW = $clog2(MaxTimers + 1);

  // Largest timeout the wheel can represent: SlotsPerLevel^Levels - 1, capped by the time width.
  function automatic longint unsigned horizon_f();
    longint unsigned h;
    h = 64'd1;
    for (int i = 0; i < Levels; i++) begin
      h = h * SlotsPerLevel;
      if (h > (64'd1 << TimeW)) begin
        h = 64'd1 << TimeW;
      end
    end
    if (h < 64'd2) begin
      return 64'd1;
    end
    return h - 64'd1;
  endfunction

  localparam logic [TimeW-1:0] Horizon = TimeW'(horizon_f());

  // Operation and result kind codes.
  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpDel   = 2'd1,
    OpReset = 2'd2,
    OpTick  = 2'd3
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StPut
  } state_e;

  // One word of the timer table memory.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expiry;
  } entry_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic [1:0]       operation;
    logic [IdW-1:0]   timer_id_in;
    logic [TimeW-1:0] timeout_ticks;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]     kind;
    logic [IdW-1:0] timer_id;
    logic           ok;
    logic           last;
  } result_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  // Write port of the table memory.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } ram_wr_t;

  // A zero timeout counts as one tick; long timeouts saturate to the horizon.
  function automatic logic [TimeW-1:0] clamp_f(input logic [TimeW-1:0] t);
    logic [TimeW-1:0] v;
    v = t;
    if (v == '0) begin
      v = TimeW'(1);
    end
    if (v > Horizon) begin
      v = Horizon;
    end
    return v;
  endfunction

endpackage

FILE: rtl/twsch_in_if.sv
// Request channel of the timer wheel scheduler.
interface twsch_in_if import twsch_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [IdW-1:0]   timer_id_in;
  logic [TimeW-1:0] timeout_ticks;

  modport source (output valid, output operation, output timer_id_in, output timeout_ticks,
                  input ready);
  modport sink (input valid, input operation, input timer_id_in, input timeout_ticks,
                output ready);
endinterface

FILE: rtl/twsch_out_if.sv
// Result channel of the timer wheel scheduler.
interface twsch_out_if import twsch_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [1:0]     kind;
  logic [IdW-1:0] timer_id;
  logic           ok;
  logic           last;

  modport source (output valid, output kind, output timer_id, output ok, output last,
                  input ready);
  modport sink (input valid, input kind, input timer_id, input ok, input last,
                output ready);
endinterface

FILE: rtl/twsch_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module twsch_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                            wr_data_i,
  input  logic                                        rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                            rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/twsch_ctrl.sv
// Scan controller: walks the timer table, updates it and produces results.
module twsch_ctrl import twsch_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  req_t            req_i,
  input  logic            out_free_i,
  output push_t           push_o,
  output ram_wr_t         ram_wr_o,
  output logic            ram_rd_en_o,
  output logic [IdxW-1:0] ram_rd_addr_o,
  input  entry_t          ram_rd_data_i
);

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [IdW-1:0]         id_in_q, id_in_d;
  logic [TimeW-1:0]       exp_q, exp_d;
  logic [TimeW-1:0]       time_q, time_d;
  logic [IdW-1:0]         next_id_q, next_id_d;
  logic [MaxTimers-1:0]   valid_q, valid_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic                   chk_v_q, chk_v_d;
  logic [IdxW-1:0]        chk_idx_q, chk_idx_d;
  logic                   pend_v_q, pend_v_d;
  result_t                pend_q, pend_d;

  logic hit, at_end, stall, step, stop, rd_en;

  // Decode of the entry whose data the memory presents this cycle.
  always_comb begin
    hit = 1'b0;
    case (op_q)
      OpAdd:           hit = !valid_q[chk_idx_q];
      OpDel, OpReset:  hit = valid_q[chk_idx_q] && (ram_rd_data_i.id == id_in_q);
      OpTick:          hit = valid_q[chk_idx_q] && (ram_rd_data_i.expiry == time_q);
      default:         hit = 1'b0;
    endcase
    at_end = (chk_idx_q == IdxW'(MaxTimers - 1));
    // A second expiry needs the held one to move out first.
    stall  = (state_q == StScan) && chk_v_q && (op_q == OpTick) && hit && pend_v_q
             && !out_free_i;
    step   = (state_q == StScan) && chk_v_q && !stall;
    stop   = step && (at_end || (hit && (op_q != OpTick)));
    rd_en  = (state_q == StScan) && !stall && !stop && (idx_q < CntW'(MaxTimers));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (req_valid_i) begin
        state_d = StScan;
      end
      StScan: if (stop) begin
        state_d = StPut;
      end
      StPut: if (out_free_i) begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs toward the channel, the output register and the memory.
  always_comb begin
    req_ready_o   = (state_q == StIdle);
    ram_rd_en_o   = rd_en;
    ram_rd_addr_o = idx_q[IdxW-1:0];
    push_o        = '0;
    ram_wr_o      = '0;
    case (state_q)
      StScan: begin
        if (step && hit && (op_q == OpTick) && pend_v_q) begin
          push_o.push     = 1'b1;
          push_o.res      = pend_q;
          push_o.res.last = 1'b0;
        end
        if (step && hit && (op_q == OpAdd || op_q == OpReset)) begin
          ram_wr_o.en          = 1'b1;
          ram_wr_o.addr        = chk_idx_q;
          ram_wr_o.data.expiry = exp_q;
          ram_wr_o.data.id     = (op_q == OpAdd) ? next_id_q : ram_rd_data_i.id;
        end
      end
      StPut: if (out_free_i) begin
        push_o.push     = 1'b1;
        push_o.res      = pend_q;
        push_o.res.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath and table state updates.
  always_comb begin
    op_d      = op_q;
    id_in_d   = id_in_q;
    exp_d     = exp_q;
    time_d    = time_q;
    next_id_d = next_id_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    chk_v_d   = chk_v_q;
    chk_idx_d = chk_idx_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    case (state_q)
      StIdle: if (req_valid_i) begin
        op_d     = op_e'(req_i.operation);
        id_in_d  = req_i.timer_id_in;
        exp_d    = time_q + clamp_f(req_i.timeout_ticks);
        if (op_e'(req_i.operation) == OpTick) begin
          time_d = time_q + TimeW'(1);
        end
        idx_d    = '0;
        chk_v_d  = 1'b0;
        pend_v_d = 1'b0;
      end
      StScan: begin
        // Read pipeline: one table entry issued per cycle unless a stall holds the scan.
        if (rd_en) begin
          idx_d     = idx_q + CntW'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q[IdxW-1:0];
        end else if (step) begin
          chk_v_d   = 1'b0;
        end
        // Matching entry.
        if (step && hit) begin
          pend_v_d      = 1'b1;
          pend_d.kind   = op_q;
          pend_d.ok     = 1'b1;
          pend_d.last   = 1'b1;
          pend_d.timer_id = id_in_q;
          case (op_q)
            OpAdd: begin
              valid_d[chk_idx_q] = 1'b1;
              pend_d.timer_id    = next_id_q;
              next_id_d          = next_id_q + IdW'(1);
            end
            OpDel:   valid_d[chk_idx_q] = 1'b0;
            OpReset: ;
            OpTick: begin
              valid_d[chk_idx_q] = 1'b0;
              pend_d.timer_id    = ram_rd_data_i.id;
            end
            default: ;
          endcase
        end
        // Scan finished without a match.
        if (step && !hit && at_end) begin
          if (op_q != OpTick) begin
            pend_v_d        = 1'b1;
            pend_d.kind     = op_q;
            pend_d.timer_id = (op_q == OpAdd) ? '0 : id_in_q;
            pend_d.ok       = 1'b0;
            pend_d.last     = 1'b1;
          end else if (!pend_v_q) begin
            pend_v_d        = 1'b1;
            pend_d.kind     = OpTick;
            pend_d.timer_id = '0;
            pend_d.ok       = 1'b0;
            pend_d.last     = 1'b1;
          end
        end
      end
      StPut: if (out_free_i) begin
        pend_v_d = 1'b0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      op_q      <= OpAdd;
      time_q    <= '0;
      next_id_q <= '0;
      valid_q   <= '0;
      idx_q     <= '0;
      chk_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      time_q    <= time_d;
      next_id_q <= next_id_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      chk_v_q   <= chk_v_d;
      pend_v_q  <= pend_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    id_in_q   <= id_in_d;
    exp_q     <= exp_d;
    chk_idx_q <= chk_idx_d;
    pend_q    <= pend_d;
  end

endmodule

FILE: rtl/timer_wheel_scheduler_core.sv
// Top level of the timer wheel scheduler: table memory, scan controller and output register.
//
// Add, delete, reset and tick requests enter one at a time. Each request scans the 64-entry
// timer table, one entry per cycle through the table memory's single read port: add stops at
// the first free entry, delete and reset at the first entry with a matching id, while a tick
// always visits every entry and its scan is held only when the result side stalls. Results
// go out through an output register, so the next request is taken while the last result
// still waits. Entry valid bits are flip-flops cleared by reset, so no clearing pass follows reset.
module timer_wheel_scheduler_core import twsch_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  twsch_in_if.sink   in_i,
  twsch_out_if.source out_o
);

  req_t            req;
  push_t           push;
  ram_wr_t         ram_wr;
  logic            ram_rd_en;
  logic [IdxW-1:0] ram_rd_addr;
  entry_t          ram_rd_data;
  logic            out_free;
  logic            out_v_q;
  result_t         out_res_q;

  assign req.operation     = in_i.operation;
  assign req.timer_id_in   = in_i.timer_id_in;
  assign req.timeout_ticks = in_i.timeout_ticks;

  // Timer table: id and expiry time of each entry.
  twsch_ram #(
    .Width ($bits(entry_t)),
    .Depth (MaxTimers)
  ) u_twsch_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr.en),
    .wr_addr_i (ram_wr.addr),
    .wr_data_i (ram_wr.data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  twsch_ctrl u_twsch_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_i.valid),
    .req_ready_o   (in_i.ready),
    .req_i         (req),
    .out_free_i    (out_free),
    .push_o        (push),
    .ram_wr_o      (ram_wr),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data)
  );

  // The output register is free when empty or when its result transfers this cycle.
  assign out_free = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push.push) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.push) begin
      out_res_q <= push.res;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.kind     = out_res_q.kind;
  assign out_o.timer_id = out_res_q.timer_id;
  assign out_o.ok       = out_res_q.ok;
  assign out_o.last     = out_res_q.last;

endmodule

FILE: rtl/twsch_checker.sv
// Port-level checks of the timer wheel scheduler, bound to its top level.
module twsch_checker import twsch_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  twsch_in_if.sink    in_i,
  twsch_out_if.source out_o
);

  // A taken request makes the request channel drop ready while the block works on it.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request channel ready right after a transfer");

  // Add, delete and reset each give a single result.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != OpTick) |-> out_o.last)
    else $error("non-tick result without last marker");

  // An empty tick report stands alone and carries no id.
  a_empty_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == OpTick && !out_o.ok) |-> (out_o.last && out_o.timer_id == '0))
    else $error("malformed empty tick report");

  // A refused add hands out no id.
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == OpAdd && !out_o.ok) |-> (out_o.timer_id == '0))
    else $error("refused add carries an id");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.kind)
      && $stable(out_o.timer_id) && $stable(out_o.ok) && $stable(out_o.last)))
    else $error("stalled result changed");

endmodule

bind timer_wheel_scheduler_core twsch_checker u_twsch_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
